// ----- hw/rtl/rpg_pkg.sv -----
// shared types, constants and the color wheel mapping for the rainbow pixel generator
package rpg_pkg;

    // strip and field sizes
    localparam int MAX_PIXELS = 64;
    localparam int IDX_W      = $clog2(MAX_PIXELS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int LEN_W      = 15;
    localparam int COLOR_W    = 8;
    localparam int FRAC_W     = 8;
    localparam int DVD_W      = IDX_W + FRAC_W;
    localparam int STEP_W     = $clog2(DVD_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEN_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_LENGTH = 1'b1;

    // register reset values
    localparam logic [CNT_W-1:0] PIXEL_COUNT_RST   = CNT_W'(60);
    localparam logic [LEN_W-1:0] EFFECT_LENGTH_RST = LEN_W'(15);

    // wheel segment bounds
    localparam logic [COLOR_W-1:0] SEG_1 = 8'd85;
    localparam logic [COLOR_W-1:0] SEG_2 = 8'd170;
    localparam logic [COLOR_W-1:0] FULL  = 8'd255;

    // controller to datapath commands
    typedef struct packed {
        logic frame_start;
        logic div_step;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic cfg_empty;
        logic div_last;
        logic out_free;
        logic last_pixel;
    } t_status;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_color;

    // wheel position to color, three ramps of step 3
    function automatic t_color wheel_color(input logic [COLOR_W-1:0] pos);
        logic [COLOR_W-1:0] p;
        logic [COLOR_W-1:0] q;
        logic [COLOR_W-1:0] q3;
        t_color c;
        p = ~pos;
        if (p < SEG_1) begin
            q = p;
        end else if (p < SEG_2) begin
            q = p - SEG_1;
        end else begin
            q = p - SEG_2;
        end
        q3 = q + {q[COLOR_W-2:0], 1'b0};
        if (p < SEG_1) begin
            c.red   = FULL - q3;
            c.green = '0;
            c.blue  = q3;
        end else if (p < SEG_2) begin
            c.red   = '0;
            c.green = q3;
            c.blue  = FULL - q3;
        end else begin
            c.red   = q3;
            c.green = FULL - q3;
            c.blue  = '0;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/rpg_tick_if.sv -----
// frame tick request channel
interface rpg_tick_if;
    logic valid;
    logic ready;
    logic frame_tick;

    modport source (output valid, output frame_tick, input ready);
    modport sink   (input valid, input frame_tick, output ready);
endinterface

// ----- hw/rtl/rpg_pixel_if.sv -----
// pixel color request channel
interface rpg_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [rpg_pkg::IDX_W-1:0]   pixel_index;
    logic [rpg_pkg::COLOR_W-1:0] first_byte;
    logic [rpg_pkg::COLOR_W-1:0] second_byte;
    logic [rpg_pkg::COLOR_W-1:0] third_byte;
    logic                         last_pixel;

    modport source (output valid, output pixel_index, output first_byte, output second_byte,
                    output third_byte, output last_pixel, input ready);
    modport sink   (input valid, input pixel_index, input first_byte, input second_byte,
                    input third_byte, input last_pixel, output ready);
endinterface

// ----- hw/rtl/rpg_ctrl.sv -----
// frame sequencer: divide each pixel, then hand it to the output register
module rpg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tick_valid,
    input  logic            i_frame_tick,
    output logic            o_tick_ready,
    input  rpg_pkg::t_status i_status,
    output rpg_pkg::t_cmd    o_cmd
);
    import rpg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_tick_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_tick_ready = 1'b1;
                if (i_tick_valid && i_frame_tick) begin
                    o_cmd.frame_start = 1'b1;
                    if (!i_status.cfg_empty) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_status.last_pixel ? S_IDLE : S_DIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/rpg_datapath.sv -----
// config registers, phase, serial divider, wheel mapping and output register
module rpg_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  rpg_pkg::t_cmd                  i_cmd,
    output rpg_pkg::t_status               o_status,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [rpg_pkg::IDX_W-1:0]      o_pixel_index,
    output logic [rpg_pkg::COLOR_W-1:0]    o_first_byte,
    output logic [rpg_pkg::COLOR_W-1:0]    o_second_byte,
    output logic [rpg_pkg::COLOR_W-1:0]    o_third_byte,
    output logic                           o_last_pixel
);
    import rpg_pkg::*;

    logic [CNT_W-1:0]   r_cfg_count;
    logic [LEN_W-1:0]   r_cfg_len;
    logic [COLOR_W-1:0] r_phase;
    logic [CNT_W-1:0]   r_count;
    logic [LEN_W-1:0]   r_len;
    logic [IDX_W-1:0]   r_idx;
    logic [DVD_W-1:0]   r_dvd;
    logic [LEN_W-1:0]   r_rem;
    logic [DVD_W-1:0]   r_quo;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    t_color             r_out_color;
    logic               r_out_last;

    logic [LEN_W:0]     rem_sh;
    logic               ge;
    logic [LEN_W:0]     diff;
    logic [IDX_W-1:0]   next_idx;
    logic               last;
    logic [COLOR_W-1:0] pos;
    t_color             color;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= PIXEL_COUNT_RST;
            r_cfg_len   <= EFFECT_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PIXEL_COUNT:   r_cfg_count <= i_cfg_data[CNT_W-1:0];
                CFG_EFFECT_LENGTH: r_cfg_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // phase advances once per frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.frame_start) begin
            r_phase <= r_phase + 1'b1;
        end
    end

    // restoring divider step
    assign rem_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign diff     = rem_sh - {1'b0, r_len};
    assign ge       = rem_sh >= {1'b0, r_len};
    assign next_idx = r_idx + 1'b1;
    assign last     = ({1'b0, r_idx} + 1'b1) == r_count;

    // frame latch, pixel index and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_start) begin
            r_count <= (r_cfg_count > CNT_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : r_cfg_count;
            r_len   <= (r_cfg_len == '0) ? LEN_W'(1) : r_cfg_len;
            r_idx   <= '0;
            r_dvd   <= '0;
            r_rem   <= '0;
            r_step  <= '0;
        end else if (i_cmd.emit) begin
            r_idx   <= next_idx;
            r_dvd   <= {next_idx, {FRAC_W{1'b0}}};
            r_rem   <= '0;
            r_step  <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd   <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem   <= ge ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            r_quo   <= {r_quo[DVD_W-2:0], ge};
            r_step  <= r_step + 1'b1;
        end
    end

    // wheel lookup on the finished quotient
    assign pos   = r_quo[COLOR_W-1:0] + r_phase;
    assign color = wheel_color(pos);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_idx   <= r_idx;
            r_out_color <= color;
            r_out_last  <= last;
        end
    end

    // status to the controller
    assign o_status.cfg_empty  = r_cfg_count == '0;
    assign o_status.div_last   = r_step == STEP_W'(DVD_W - 1);
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.last_pixel = last;

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_out_idx;
    assign o_first_byte  = r_out_color.blue;
    assign o_second_byte = r_out_color.green;
    assign o_third_byte  = r_out_color.red;
    assign o_last_pixel  = r_out_last;

endmodule

// ----- hw/rtl/rainbow_pixel_generator_unit.sv -----
// Rainbow pixel generator: each accepted frame tick request advances the wheel phase by one
// and then emits one color request per LED, pixel 0 first, with blue, green and red in the
// first, second and third byte and the last pixel flagged. The effective pixel count is the
// pixel_count register clamped to 64; zero gives no pixels but still advances the phase, and
// an effect_length of zero acts as one. Each pixel runs 14 steps of a one bit per cycle
// restoring divider that forms (index*256)/effect_length, then loads the output register.
// A tick of zero is accepted and does nothing. The user must write the configuration
// between frames; the block does not enforce this.
module rainbow_pixel_generator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rpg_tick_if.sink                       i_tick,
    rpg_pixel_if.source                    o_pix,
    input  logic                           i_cfg_we,
    input  logic [rpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rpg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rpg_pkg::*;

    t_cmd    cmd;
    t_status status;

    // frame sequencer
    rpg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (i_tick.valid),
        .i_frame_tick (i_tick.frame_tick),
        .o_tick_ready (i_tick.ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // arithmetic and output register
    rpg_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (o_pix.ready),
        .o_out_valid   (o_pix.valid),
        .o_pixel_index (o_pix.pixel_index),
        .o_first_byte  (o_pix.first_byte),
        .o_second_byte (o_pix.second_byte),
        .o_third_byte  (o_pix.third_byte),
        .o_last_pixel  (o_pix.last_pixel)
    );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// testbench for the rainbow pixel generator: frame tick requests checked against a wheel predictor
module tb;
    import rpg_pkg::*;

    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_GAP        = 19;

    // one pixel color request as seen on the output channel
    typedef struct {
        logic [IDX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] first_byte;
        logic [COLOR_W-1:0] second_byte;
        logic [COLOR_W-1:0] third_byte;
        logic               last_pixel;
    } t_pixel_req;

    // shadow registers, wheel phase and the pixel requests still owed by the block
    class rainbow_scoreboard;
        logic [CNT_W-1:0]   pixel_count;
        logic [LEN_W-1:0]   effect_length;
        logic [COLOR_W-1:0] phase;
        t_pixel_req         pixel_q[$];
        int                 errors;

        function new();
            pixel_count   = PIXEL_COUNT_RST;
            effect_length = EFFECT_LENGTH_RST;
            phase         = '0;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PIXEL_COUNT:   pixel_count = data[CNT_W-1:0];
                CFG_EFFECT_LENGTH: effect_length = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // inverted position split over three ramps of step 3
        function t_color wheel(logic [COLOR_W-1:0] pos);
            int     p;
            int     q;
            t_color c;
            p = FULL - pos;
            if (p < SEG_1) begin
                q       = p;
                c.red   = COLOR_W'(FULL - 3 * q);
                c.green = '0;
                c.blue  = COLOR_W'(3 * q);
            end else if (p < SEG_2) begin
                q       = p - SEG_1;
                c.red   = '0;
                c.green = COLOR_W'(3 * q);
                c.blue  = COLOR_W'(FULL - 3 * q);
            end else begin
                q       = p - SEG_2;
                c.red   = COLOR_W'(3 * q);
                c.green = COLOR_W'(FULL - 3 * q);
                c.blue  = '0;
            end
            return c;
        endfunction

        // accepted frame tick: step the phase and queue one color per pixel
        function void note_tick(logic tick);
            int         count;
            int         len;
            int         pos;
            t_color     c;
            t_pixel_req px;
            if (tick !== 1'b1) return;
            phase = phase + 1'b1;
            count = (pixel_count > MAX_PIXELS) ? MAX_PIXELS : int'(pixel_count);
            len   = (effect_length == 0) ? 1 : int'(effect_length);
            for (int i = 0; i < count; i++) begin
                pos            = ((i * 256) / len + int'(phase)) & 255;
                c              = wheel(COLOR_W'(pos));
                px.pixel_index = IDX_W'(i);
                px.first_byte  = c.blue;
                px.second_byte = c.green;
                px.third_byte  = c.red;
                px.last_pixel  = (i == count - 1);
                pixel_q.push_back(px);
            end
        endfunction

        function void check_field(string name, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // compare one accepted pixel request with the oldest one owed
        function void check_pixel(t_pixel_req got);
            t_pixel_req want;
            if (pixel_q.size() == 0) begin
                $error("pixel_index: expected no request, got %0d", got.pixel_index);
                errors++;
                return;
            end
            want = pixel_q.pop_front();
            check_field("pixel_index", COLOR_W'(want.pixel_index), COLOR_W'(got.pixel_index));
            check_field("first_byte", want.first_byte, got.first_byte);
            check_field("second_byte", want.second_byte, got.second_byte);
            check_field("third_byte", want.third_byte, got.third_byte);
            check_field("last_pixel", COLOR_W'(want.last_pixel), COLOR_W'(got.last_pixel));
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rpg_tick_if  tick_ch ();
    rpg_pixel_if pix_ch ();

    rainbow_scoreboard frame_sb;
    bit                no_idle  = 1'b0;
    bit                hold_req = 1'b0;
    int                quiet_cycles = 0;

    rainbow_pixel_generator_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick_ch),
        .o_pix      (pix_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // watchdog on cycles without any request or register write
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || i_cfg_we === 1'b1 ||
            (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
            (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // pixel sink with random stalls and one long hold-off on request
    initial begin : pixel_sink
        int         gap;
        t_pixel_req got;
        pix_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        gap = 0;
        forever begin
            if (gap > 0) begin
                pix_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pix_ch.ready <= 1'b1;
            do @(posedge i_clk); while (pix_ch.valid !== 1'b1);
            got.pixel_index = pix_ch.pixel_index;
            got.first_byte  = pix_ch.first_byte;
            got.second_byte = pix_ch.second_byte;
            got.third_byte  = pix_ch.third_byte;
            got.last_pixel  = pix_ch.last_pixel;
            frame_sb.check_pixel(got);
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = HOLD_CYCLES;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
        end
    end

    // offer one frame tick request, eager skips the random gap
    task automatic send_tick(input logic tick, input bit eager);
        int gap;
        gap = (no_idle || eager) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.frame_tick <= tick;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        frame_sb.note_tick(tick);
    endtask

    // stop offering and wait until every owed pixel has come and the block is idle
    task automatic drain();
        tick_ch.valid <= 1'b0;
        while (frame_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers on consecutive edges, block idle
    task automatic configure(input logic [CFG_DATA_W-1:0] count_data,
                             input logic [CFG_DATA_W-1:0] len_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PIXEL_COUNT;
        i_cfg_data <= count_data;
        @(posedge i_clk);
        frame_sb.write_reg(CFG_PIXEL_COUNT, count_data);
        i_cfg_idx  <= CFG_EFFECT_LENGTH;
        i_cfg_data <= len_data;
        @(posedge i_clk);
        frame_sb.write_reg(CFG_EFFECT_LENGTH, len_data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_frames(input logic [CFG_DATA_W-1:0] count_data,
                              input logic [CFG_DATA_W-1:0] len_data,
                              input int n, input int zero_pct);
        configure(count_data, len_data);
        repeat (n) send_tick($urandom_range(0, 99) >= zero_pct, 1'b0);
        drain();
    endtask

    // pixel count: mostly in range, some zero and some above the maximum, random upper bits
    function automatic logic [CFG_DATA_W-1:0] rand_count();
        int               r;
        logic [CNT_W-1:0] cnt;
        r = $urandom_range(0, 19);
        if (r == 0) cnt = '0;
        else if (r == 1) cnt = CNT_W'($urandom_range(MAX_PIXELS + 1, 127));
        else if (r == 2) cnt = CNT_W'(MAX_PIXELS);
        else if (r == 3) cnt = CNT_W'(1);
        else cnt = CNT_W'($urandom_range(2, MAX_PIXELS - 1));
        if ($urandom_range(0, 1) == 0) return {(CFG_DATA_W - CNT_W)'(0), cnt};
        return {(CFG_DATA_W - CNT_W)'($urandom), cnt};
    endfunction

    // effect length: mostly short, some zero, full range and the top
    function automatic logic [CFG_DATA_W-1:0] rand_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return CFG_DATA_W'($urandom_range(0, 32767));
        if (r == 2) return ($urandom_range(0, 1) == 0) ? CFG_DATA_W'(16384) : '1;
        return CFG_DATA_W'($urandom_range(1, 300));
    endfunction

    // main sequence
    initial begin
        frame_sb = new();
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_PIXEL_COUNT;
        i_cfg_data         <= '0;
        tick_ch.valid      <= 1'b0;
        tick_ch.frame_tick <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, a zero tick leaves the phase alone
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        drain();
        // single pixel on the shortest wheel
        run_frames(CFG_DATA_W'(1), CFG_DATA_W'(1), 2, 0);
        // full strip on a long effect
        run_frames(CFG_DATA_W'(MAX_PIXELS), CFG_DATA_W'(16384), 2, 0);
        // zero pixels: phase moves, nothing comes out
        run_frames(CFG_DATA_W'(0), CFG_DATA_W'(15), 2, 0);
        send_tick(1'b0, 1'b0);
        drain();
        // count above the maximum with all data bits set, zero length
        run_frames('1, '0, 2, 0);
        run_frames({8'hA5, 7'd65}, '1, 2, 0);
        run_frames(CFG_DATA_W'(MAX_PIXELS), CFG_DATA_W'(1), 2, 0);
        run_frames(CFG_DATA_W'(37), CFG_DATA_W'(128), 2, 0);

        // random settings, some phases without idling
        for (int ph = 0; ph < 14; ph++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            run_frames(rand_count(), rand_len(), $urandom_range(15, 30), 10);
        end
        no_idle = 1'b0;

        // sink holds off while ticks keep coming so the input stalls
        configure(CFG_DATA_W'(MAX_PIXELS), rand_len());
        send_tick(1'b1, 1'b1);
        hold_req = 1'b1;
        repeat (4) send_tick(1'b1, 1'b1);
        drain();

        if (frame_sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/rpg_pkg.sv
hw/rtl/rpg_tick_if.sv
hw/rtl/rpg_pixel_if.sv
hw/rtl/rpg_ctrl.sv
hw/rtl/rpg_datapath.sv
hw/rtl/rainbow_pixel_generator_unit.sv
test/tb.sv
